[design/hdrbg_pkg.sv]
// Shared constants, codes, tables and interface types of the Hash_DRBG generator.
`timescale 1ns / 1ps
package hdrbg_pkg;

	localparam int MAX_SEED_BYTES  = 128;
	localparam int MAX_ADDIN_BYTES = 64;
	localparam int MAX_OUT_WORDS   = 64;

	localparam int SEED_BYTES = 55;
	localparam int VEC_BITS   = 448;
	localparam int SEED_AW    = ($clog2(MAX_SEED_BYTES) > 0) ? $clog2(MAX_SEED_BYTES) : 1;
	localparam int SEED_CW    = $clog2(MAX_SEED_BYTES + 1);
	localparam int ADDIN_AW   = ($clog2(MAX_ADDIN_BYTES) > 0) ? $clog2(MAX_ADDIN_BYTES) : 1;
	localparam int ADDIN_CW   = $clog2(MAX_ADDIN_BYTES + 1);
	localparam int OUT_BYTES  = MAX_OUT_WORDS * 8;
	localparam int REQ_MAX    = MAX_OUT_WORDS * 64;
	localparam int REM_W      = $clog2(OUT_BYTES + 1);
	localparam int POS_W      = $clog2(MAX_SEED_BYTES + MAX_ADDIN_BYTES + 256);

	localparam logic [63:0] TOP_MASK = 64'h00ff_ffff_ffff_ffff;

	localparam logic [1:0] CMD_SEED  = 2'd0;
	localparam logic [1:0] CMD_ADDIN = 2'd1;
	localparam logic [1:0] CMD_INST  = 2'd2;
	localparam logic [1:0] CMD_GEN   = 2'd3;

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_DF1_SEED = 3'd0;
	localparam kind_t KIND_DF2_SEED = 3'd1;
	localparam kind_t KIND_DF1_V    = 3'd2;
	localparam kind_t KIND_DF2_V    = 3'd3;
	localparam kind_t KIND_ADDIN    = 3'd4;
	localparam kind_t KIND_GEN      = 3'd5;
	localparam kind_t KIND_UPD      = 3'd6;

	localparam logic TGT_V    = 1'b0;
	localparam logic TGT_DATA = 1'b1;

	localparam logic [1:0] OP_DIG = 2'd0;
	localparam logic [1:0] OP_C   = 2'd1;
	localparam logic [1:0] OP_CNT = 2'd2;
	localparam logic [1:0] OP_ONE = 2'd3;

	typedef struct packed {
		logic       seed_wr;
		logic       addin_wr;
		logic       seed_clr;
		logic       addin_clr;
		logic       msg_start;
		kind_t      msg_kind;
		logic       fill_en;
		logic       sha_start;
		logic       hold_dig;
		logic       v_from_df;
		logic       c_from_df;
		logic       add_start;
		logic       add_tgt;
		logic [1:0] add_op;
		logic       data_load;
		logic       cnt_set1;
		logic       cnt_inc;
		logic       req_load;
		logic       wsel_clr;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic sha_busy;
		logic add_busy;
		logic fill_last;
		logic msg_more;
		logic addin_nz;
		logic rem_nz;
		logic rem_le8;
		logic wsel_last;
		logic out_free;
	} dp_stat_t;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

[design/hash_drbg_sha256_generator_core.sv]
// Top level of the Hash_DRBG SHA-256 generator.
//
//   group  dir  payload (low bits first)                           transaction
//   s_     in   tuser: command; tdata: data_byte, request_bits     one command
//   m_     out  tdata: random_word, valid_bytes; tlast: last       one output word
//
// Each seed or additional-input byte is one command. Every SHA-256 block is first
// built one byte a cycle, then compressed in the one-round-per-cycle compression
// unit. Each 440-bit addition runs in the 64-bit word-serial adder. Instantiate
// costs 6 to 10 blocks; a generate costs two or three blocks for additional input,
// ceil(bytes/32) blocks and two update blocks, plus up to four additions and one
// increment per further digest. Reset clears V, C, the counter and the byte counts
// at once. A stalled output word holds the controller until it is taken; input is
// taken only between commands.
`timescale 1ns / 1ps
module hash_drbg_sha256_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte [7:0], request_bits [20:8]
	input  logic [1:0]  s_tuser,   // command [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // random_word [63:0], valid_bytes [67:64]
	output logic        m_tlast
);

	hdrbg_pkg::dp_cmd_t  cmd;
	hdrbg_pkg::dp_stat_t stat;

	hdrbg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.command  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hdrbg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (s_tdata[7:0]),
		.request_bits (s_tdata[20:8]),
		.cmd          (cmd),
		.stat         (stat),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

endmodule

[design/hdrbg_sha_core.sv]
// Iterative SHA-256 compression unit, one round per cycle.
`timescale 1ns / 1ps
module hdrbg_sha_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         first,
	input  logic [511:0] block,
	output logic         busy,
	output logic [255:0] digest
);

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	logic        busy_q;
	logic [6:0]  rnd_q;
	logic [31:0] st_q [8];
	logic [31:0] w_q [16];
	logic [31:0] hv_q [8];
	logic [31:0] t1, t2, w_new, big_s0, big_s1, ch, maj, sm0, sm1;

	always_comb begin
		big_s1 = rotr(st_q[4], 6) ^ rotr(st_q[4], 11) ^ rotr(st_q[4], 25);
		big_s0 = rotr(st_q[0], 2) ^ rotr(st_q[0], 13) ^ rotr(st_q[0], 22);
		ch     = (st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6]);
		maj    = (st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]);
		t1     = st_q[7] + big_s1 + ch + hdrbg_pkg::SHA_K[rnd_q[5:0]] + w_q[0];
		t2     = big_s0 + maj;
		sm0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		sm1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new  = w_q[0] + sm0 + w_q[9] + sm1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			rnd_q  <= '0;
		end else if (busy_q) begin
			if (rnd_q == 7'd64) begin
				busy_q <= 1'b0;
			end
			rnd_q <= rnd_q + 7'd1;
		end
	end

	// Round 64 is the final feed-forward into the chaining value.
	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= block[511 - 32 * i -: 32];
			end
			for (int i = 0; i < 8; i++) begin
				st_q[i] <= first ? hdrbg_pkg::SHA_IV[i] : hv_q[i];
				if (first) begin
					hv_q[i] <= hdrbg_pkg::SHA_IV[i];
				end
			end
		end else if (busy_q) begin
			if (rnd_q == 7'd64) begin
				for (int i = 0; i < 8; i++) begin
					hv_q[i] <= hv_q[i] + st_q[i];
				end
			end else begin
				st_q[0] <= t1 + t2;
				st_q[1] <= st_q[0];
				st_q[2] <= st_q[1];
				st_q[3] <= st_q[2];
				st_q[4] <= st_q[3] + t1;
				st_q[5] <= st_q[4];
				st_q[6] <= st_q[5];
				st_q[7] <= st_q[6];
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[15] <= w_new;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			digest[255 - 32 * i -: 32] = hv_q[i];
		end
	end

	assign busy = busy_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("compression did not start");

endmodule

[design/hdrbg_datapath.sv]
// Datapath: byte buffers, message builder, hash unit, wide state and output register.
`timescale 1ns / 1ps
module hdrbg_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic [12:0]         request_bits,
	input  hdrbg_pkg::dp_cmd_t  cmd,
	output hdrbg_pkg::dp_stat_t stat,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [71:0]         m_tdata,
	output logic                m_tlast
);

	localparam int PW = hdrbg_pkg::POS_W;

	// Wide state, least significant word in the low bits, top byte always zero.
	logic [hdrbg_pkg::VEC_BITS-1:0] v_q, c_q, data_q;
	logic [63:0]                    cnt_q;
	logic [hdrbg_pkg::SEED_CW-1:0]  seed_cnt_q;
	logic [hdrbg_pkg::ADDIN_CW-1:0] addin_cnt_q;
	logic [7:0] seed_mem [hdrbg_pkg::MAX_SEED_BYTES];
	logic [7:0] addin_mem [hdrbg_pkg::MAX_ADDIN_BYTES];
	logic [7:0] seed_rd_q, addin_rd_q;

	// Message builder.
	hdrbg_pkg::kind_t kind_q;
	logic [PW-1:0] pos_q, len_q, pad_w, hl, nl, num_off, buf_off, len_off;
	logic          first_q;
	logic          vld_s1, use_seed_s1, use_addin_s1;
	logic [7:0]    cbyte_s1, byte_s2, hb, nbyte, lbyte, cbyte;
	logic          use_seed, use_addin;
	logic [63:0]   bitlen;
	logic [5:0]    vidx;
	logic [511:0]  block_q;
	logic [hdrbg_pkg::VEC_BITS-1:0] num_src;
	logic [255:0]  hold_q, digest;
	logic          sha_busy;

	// Word-serial adder.
	logic        add_busy_q, add_tgt_q, carry_q;
	logic [1:0]  add_op_q;
	logic [2:0]  aw_q;
	logic [63:0] add_a, add_b, add_res;
	logic [64:0] add_sum;

	// Output side.
	logic [hdrbg_pkg::REM_W-1:0] rem_q, nb;
	logic [12:0] rb;
	logic [1:0]  wsel_q;
	logic [3:0]  wcnt;
	logic [63:0] word, wmask;
	logic        out_vld_q, out_last_q;
	logic [63:0] out_word_q;
	logic [3:0]  out_vb_q;

	always_comb begin
		pad_w = (len_q + PW'(72)) & ~PW'(63);
		hb    = 8'h00;
		hl    = '0;
		nl    = PW'(hdrbg_pkg::SEED_BYTES);
		case (kind_q)
			hdrbg_pkg::KIND_DF1_SEED, hdrbg_pkg::KIND_DF2_SEED,
			hdrbg_pkg::KIND_DF1_V, hdrbg_pkg::KIND_DF2_V: begin
				hl = (kind_q == hdrbg_pkg::KIND_DF1_SEED || kind_q == hdrbg_pkg::KIND_DF2_SEED)
					? PW'(5) : PW'(6);
				if (kind_q == hdrbg_pkg::KIND_DF1_SEED || kind_q == hdrbg_pkg::KIND_DF2_SEED) begin
					nl = '0;
				end
				case (pos_q[2:0])
					3'd0: hb = (kind_q == hdrbg_pkg::KIND_DF1_SEED || kind_q == hdrbg_pkg::KIND_DF1_V)
						? 8'h01 : 8'h02;
					3'd3: hb = 8'h01;
					3'd4: hb = 8'hb8;
					default: hb = 8'h00;
				endcase
			end
			hdrbg_pkg::KIND_ADDIN: begin
				hl = PW'(1);
				hb = 8'h02;
			end
			hdrbg_pkg::KIND_UPD: begin
				hl = PW'(1);
				hb = 8'h03;
			end
			default: begin
				hl = '0;
			end
		endcase
		num_off = pos_q - hl;
		buf_off = pos_q - hl - nl;
		len_off = pos_q - (pad_w - PW'(8));
		num_src = (kind_q == hdrbg_pkg::KIND_GEN) ? data_q : v_q;
		vidx    = 6'(hdrbg_pkg::SEED_BYTES - 1) - num_off[5:0];
		nbyte   = num_src[{vidx, 3'b000} +: 8];
		bitlen  = 64'(len_q) << 3;
		lbyte   = bitlen[{3'd7 - len_off[2:0], 3'b000} +: 8];
		use_seed  = 1'b0;
		use_addin = 1'b0;
		cbyte     = 8'h00;
		if (pos_q < len_q) begin
			if (pos_q < hl) begin
				cbyte = hb;
			end else if (pos_q < hl + nl) begin
				cbyte = nbyte;
			end else begin
				use_seed  = (kind_q == hdrbg_pkg::KIND_DF1_SEED || kind_q == hdrbg_pkg::KIND_DF2_SEED);
				use_addin = !use_seed;
			end
		end else if (pos_q == len_q) begin
			cbyte = 8'h80;
		end else if (pos_q >= pad_w - PW'(8)) begin
			cbyte = lbyte;
		end
	end

	assign byte_s2 = use_seed_s1 ? seed_rd_q : (use_addin_s1 ? addin_rd_q : cbyte_s1);

	always_ff @(posedge clk) begin
		if (cmd.seed_wr && seed_cnt_q < hdrbg_pkg::SEED_CW'(hdrbg_pkg::MAX_SEED_BYTES)) begin
			seed_mem[seed_cnt_q[hdrbg_pkg::SEED_AW-1:0]] <= data_byte;
		end
		if (cmd.addin_wr && addin_cnt_q < hdrbg_pkg::ADDIN_CW'(hdrbg_pkg::MAX_ADDIN_BYTES)) begin
			addin_mem[addin_cnt_q[hdrbg_pkg::ADDIN_AW-1:0]] <= data_byte;
		end
		seed_rd_q  <= seed_mem[buf_off[hdrbg_pkg::SEED_AW-1:0]];
		addin_rd_q <= addin_mem[buf_off[hdrbg_pkg::ADDIN_AW-1:0]];
		cbyte_s1     <= cbyte;
		use_seed_s1  <= use_seed;
		use_addin_s1 <= use_addin;
		if (vld_s1) begin
			block_q <= {block_q[503:0], byte_s2};
		end
		if (cmd.msg_start) begin
			kind_q <= cmd.msg_kind;
			case (cmd.msg_kind)
				hdrbg_pkg::KIND_DF1_SEED, hdrbg_pkg::KIND_DF2_SEED: len_q <= PW'(5) + PW'(seed_cnt_q);
				hdrbg_pkg::KIND_DF1_V, hdrbg_pkg::KIND_DF2_V:       len_q <= PW'(61);
				hdrbg_pkg::KIND_ADDIN:                              len_q <= PW'(56) + PW'(addin_cnt_q);
				hdrbg_pkg::KIND_GEN:                                len_q <= PW'(55);
				default:                                            len_q <= PW'(56);
			endcase
		end
		if (cmd.hold_dig) begin
			hold_q <= digest;
		end
		if (cmd.out_load) begin
			out_word_q <= word & wmask;
			out_vb_q   <= wcnt;
			out_last_q <= stat.rem_le8;
		end
	end

	hdrbg_sha_core u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sha_start),
		.first  (first_q),
		.block  (block_q),
		.busy   (sha_busy),
		.digest (digest)
	);

	always_comb begin
		add_a = (add_tgt_q == hdrbg_pkg::TGT_V) ? v_q[{aw_q, 6'b0} +: 64] : data_q[{aw_q, 6'b0} +: 64];
		case (add_op_q)
			hdrbg_pkg::OP_DIG: add_b = (aw_q < 3'd4) ? digest[{aw_q[1:0], 6'b0} +: 64] : 64'd0;
			hdrbg_pkg::OP_C:   add_b = c_q[{aw_q, 6'b0} +: 64];
			hdrbg_pkg::OP_CNT: add_b = (aw_q == 3'd0) ? cnt_q : 64'd0;
			default:           add_b = (aw_q == 3'd0) ? 64'd1 : 64'd0;
		endcase
		add_sum = {1'b0, add_a} + {1'b0, add_b} + 65'(carry_q);
		add_res = (aw_q == 3'd6) ? (add_sum[63:0] & hdrbg_pkg::TOP_MASK) : add_sum[63:0];
	end

	always_comb begin
		rb    = (request_bits > 13'(hdrbg_pkg::REQ_MAX)) ? 13'(hdrbg_pkg::REQ_MAX) : request_bits;
		nb    = hdrbg_pkg::REM_W'((14'(rb) + 14'd7) >> 3);
		wcnt  = stat.rem_le8 ? rem_q[3:0] : 4'd8;
		word  = digest[{2'd3 - wsel_q, 6'b0} +: 64];
		wmask = ~(64'hffff_ffff_ffff_ffff >> {wcnt, 3'b000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			c_q         <= '0;
			data_q      <= '0;
			cnt_q       <= '0;
			seed_cnt_q  <= '0;
			addin_cnt_q <= '0;
			pos_q       <= '0;
			first_q     <= 1'b0;
			vld_s1      <= 1'b0;
			add_busy_q  <= 1'b0;
			add_tgt_q   <= hdrbg_pkg::TGT_V;
			add_op_q    <= hdrbg_pkg::OP_DIG;
			aw_q        <= '0;
			carry_q     <= 1'b0;
			rem_q       <= '0;
			wsel_q      <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			vld_s1 <= cmd.fill_en;
			if (cmd.seed_wr && seed_cnt_q < hdrbg_pkg::SEED_CW'(hdrbg_pkg::MAX_SEED_BYTES)) begin
				seed_cnt_q <= seed_cnt_q + 1'b1;
			end else if (cmd.seed_clr) begin
				seed_cnt_q <= '0;
			end
			if (cmd.addin_wr && addin_cnt_q < hdrbg_pkg::ADDIN_CW'(hdrbg_pkg::MAX_ADDIN_BYTES)) begin
				addin_cnt_q <= addin_cnt_q + 1'b1;
			end else if (cmd.addin_clr) begin
				addin_cnt_q <= '0;
			end
			if (cmd.msg_start) begin
				pos_q   <= '0;
				first_q <= 1'b1;
			end else if (cmd.fill_en) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.sha_start) begin
				first_q <= 1'b0;
			end
			// Hash_df output is the first 440 bits of the two digests.
			if (cmd.v_from_df) begin
				v_q <= {8'h00, hold_q, digest[255:72]};
			end
			if (cmd.c_from_df) begin
				c_q <= {8'h00, hold_q, digest[255:72]};
			end
			if (cmd.data_load) begin
				data_q <= v_q;
			end
			if (cmd.cnt_set1) begin
				cnt_q <= 64'd1;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 64'd1;
			end
			if (cmd.add_start) begin
				add_busy_q <= 1'b1;
				add_tgt_q  <= cmd.add_tgt;
				add_op_q   <= cmd.add_op;
				aw_q       <= '0;
				carry_q    <= 1'b0;
			end else if (add_busy_q) begin
				if (add_tgt_q == hdrbg_pkg::TGT_V) begin
					v_q[{aw_q, 6'b0} +: 64] <= add_res;
				end else begin
					data_q[{aw_q, 6'b0} +: 64] <= add_res;
				end
				carry_q <= add_sum[64];
				aw_q    <= aw_q + 3'd1;
				if (aw_q == 3'd6) begin
					add_busy_q <= 1'b0;
				end
			end
			if (cmd.req_load) begin
				rem_q <= nb;
			end else if (cmd.out_load) begin
				rem_q <= rem_q - hdrbg_pkg::REM_W'(wcnt);
			end
			if (cmd.wsel_clr) begin
				wsel_q <= '0;
			end else if (cmd.out_load) begin
				wsel_q <= wsel_q + 2'd1;
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.sha_busy  = sha_busy;
		stat.add_busy  = add_busy_q;
		stat.fill_last = (pos_q[5:0] == 6'd63);
		stat.msg_more  = (pos_q < pad_w);
		stat.addin_nz  = (addin_cnt_q != '0);
		stat.rem_nz    = (rem_q != '0);
		stat.rem_le8   = (rem_q <= hdrbg_pkg::REM_W'(8));
		stat.wsel_last = (wsel_q == 2'd3);
		stat.out_free  = !out_vld_q || m_tready;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_vb_q, out_word_q};
	assign m_tlast  = out_last_q;

endmodule

[design/hdrbg_ctrl.sv]
// Controller state machine that sequences the Hash_DRBG operations.
`timescale 1ns / 1ps
module hdrbg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic [1:0]          command,
	output logic                s_tready,
	input  hdrbg_pkg::dp_stat_t stat,
	output hdrbg_pkg::dp_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MSG    = 4'd1;
	localparam logic [3:0] S_FILL   = 4'd2;
	localparam logic [3:0] S_DRAIN  = 4'd3;
	localparam logic [3:0] S_SHA    = 4'd4;
	localparam logic [3:0] S_WAIT   = 4'd5;
	localparam logic [3:0] S_HDONE  = 4'd6;
	localparam logic [3:0] S_ADD    = 4'd7;
	localparam logic [3:0] S_ADONE  = 4'd8;
	localparam logic [3:0] S_GSTART = 4'd9;
	localparam logic [3:0] S_EMIT   = 4'd10;

	localparam logic [3:0] ST_I1   = 4'd0;
	localparam logic [3:0] ST_I2   = 4'd1;
	localparam logic [3:0] ST_I3   = 4'd2;
	localparam logic [3:0] ST_I4   = 4'd3;
	localparam logic [3:0] ST_AD   = 4'd4;
	localparam logic [3:0] ST_ADDV = 4'd5;
	localparam logic [3:0] ST_GEN  = 4'd6;
	localparam logic [3:0] ST_INC  = 4'd7;
	localparam logic [3:0] ST_UPD  = 4'd8;
	localparam logic [3:0] ST_U1   = 4'd9;
	localparam logic [3:0] ST_U2   = 4'd10;
	localparam logic [3:0] ST_U3   = 4'd11;

	logic [3:0] state_q, state_d, step_q, step_d;

	function automatic hdrbg_pkg::kind_t kind_of(input logic [3:0] st);
		case (st)
			ST_I1:   kind_of = hdrbg_pkg::KIND_DF1_SEED;
			ST_I2:   kind_of = hdrbg_pkg::KIND_DF2_SEED;
			ST_I3:   kind_of = hdrbg_pkg::KIND_DF1_V;
			ST_I4:   kind_of = hdrbg_pkg::KIND_DF2_V;
			ST_AD:   kind_of = hdrbg_pkg::KIND_ADDIN;
			ST_GEN:  kind_of = hdrbg_pkg::KIND_GEN;
			default: kind_of = hdrbg_pkg::KIND_UPD;
		endcase
	endfunction

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		state_d  = state_q;
		step_d   = step_q;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (command)
						hdrbg_pkg::CMD_SEED:  cmd.seed_wr = 1'b1;
						hdrbg_pkg::CMD_ADDIN: cmd.addin_wr = 1'b1;
						hdrbg_pkg::CMD_INST: begin
							step_d  = ST_I1;
							state_d = S_MSG;
						end
						default: begin
							cmd.req_load = 1'b1;
							if (stat.addin_nz) begin
								step_d  = ST_AD;
								state_d = S_MSG;
							end else begin
								state_d = S_GSTART;
							end
						end
					endcase
				end
			end
			S_MSG: begin
				cmd.msg_start = 1'b1;
				cmd.msg_kind  = kind_of(step_q);
				state_d       = S_FILL;
			end
			S_FILL: begin
				cmd.fill_en = 1'b1;
				if (stat.fill_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_SHA;
			S_SHA: begin
				cmd.sha_start = 1'b1;
				state_d       = S_WAIT;
			end
			S_WAIT: begin
				if (!stat.sha_busy) begin
					state_d = stat.msg_more ? S_FILL : S_HDONE;
				end
			end
			S_HDONE: begin
				case (step_q)
					ST_I1: begin
						cmd.hold_dig = 1'b1;
						step_d       = ST_I2;
						state_d      = S_MSG;
					end
					ST_I2: begin
						cmd.v_from_df = 1'b1;
						step_d        = ST_I3;
						state_d       = S_MSG;
					end
					ST_I3: begin
						cmd.hold_dig = 1'b1;
						step_d       = ST_I4;
						state_d      = S_MSG;
					end
					ST_I4: begin
						cmd.c_from_df = 1'b1;
						cmd.cnt_set1  = 1'b1;
						cmd.seed_clr  = 1'b1;
						state_d       = S_IDLE;
					end
					ST_AD: begin
						cmd.add_start = 1'b1;
						cmd.add_tgt   = hdrbg_pkg::TGT_V;
						cmd.add_op    = hdrbg_pkg::OP_DIG;
						cmd.addin_clr = 1'b1;
						step_d        = ST_ADDV;
						state_d       = S_ADD;
					end
					ST_GEN: begin
						cmd.wsel_clr = 1'b1;
						state_d      = S_EMIT;
					end
					default: begin
						cmd.add_start = 1'b1;
						cmd.add_tgt   = hdrbg_pkg::TGT_V;
						cmd.add_op    = hdrbg_pkg::OP_DIG;
						step_d        = ST_U1;
						state_d       = S_ADD;
					end
				endcase
			end
			S_ADD: begin
				if (!stat.add_busy) begin
					state_d = S_ADONE;
				end
			end
			S_ADONE: begin
				case (step_q)
					ST_ADDV: state_d = S_GSTART;
					ST_INC: begin
						step_d  = ST_GEN;
						state_d = S_MSG;
					end
					ST_U1: begin
						cmd.add_start = 1'b1;
						cmd.add_tgt   = hdrbg_pkg::TGT_V;
						cmd.add_op    = hdrbg_pkg::OP_C;
						step_d        = ST_U2;
						state_d       = S_ADD;
					end
					ST_U2: begin
						cmd.add_start = 1'b1;
						cmd.add_tgt   = hdrbg_pkg::TGT_V;
						cmd.add_op    = hdrbg_pkg::OP_CNT;
						step_d        = ST_U3;
						state_d       = S_ADD;
					end
					default: begin
						cmd.cnt_inc = 1'b1;
						state_d     = S_IDLE;
					end
				endcase
			end
			S_GSTART: begin
				cmd.data_load = 1'b1;
				step_d        = stat.rem_nz ? ST_GEN : ST_UPD;
				state_d       = S_MSG;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.rem_le8) begin
						step_d  = ST_UPD;
						state_d = S_MSG;
					end else if (stat.wsel_last) begin
						cmd.add_start = 1'b1;
						cmd.add_tgt   = hdrbg_pkg::TGT_DATA;
						cmd.add_op    = hdrbg_pkg::OP_ONE;
						step_d        = ST_INC;
						state_d       = S_ADD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_I1;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	a_sha_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sha_start |-> !stat.sha_busy)
		else $error("hash started while busy");
	a_add_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_start |-> !stat.add_busy)
		else $error("addition started while busy");
	a_sha_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.sha_busy |-> state_q == S_WAIT)
		else $error("hash unit runs outside the wait state");
	a_add_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.add_busy |-> state_q == S_ADD)
		else $error("adder runs outside the wait state");

endmodule

[tb/hash_drbg_sha256_generator_core_tb.sv]
// Self-checking testbench of the Hash_DRBG SHA-256 generator core.
`timescale 1ns / 1ps
module hash_drbg_sha256_generator_core_tb;

	typedef logic [7:0] octet_t;
	typedef octet_t octet_q_t[$];

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
	} out_word_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  data;
		logic [12:0] bits;
	} stim_row_t;

	localparam int TOTAL_CMDS  = 430;
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int DRAIN_WAIT  = 20_000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tlast;

	hash_drbg_sha256_generator_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// Generator state as tracked by the testbench.
	logic [439:0] drbg_v;
	logic [439:0] drbg_c;
	logic [63:0]  drbg_ctr;
	octet_t       seed_q[$];
	octet_t       addin_q[$];
	out_word_t    expected_words[$];

	int  error_count;
	int  cycle_count;
	int  useful_cmds;
	int  words_checked;
	int  gen_count;
	int  inst_count;
	int  send_gap_pct;
	int  rx_stall_pct;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] rotr32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [255:0] sha256_of(octet_q_t msg);
		logic [31:0] h[8];
		logic [31:0] w[64];
		logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
		logic [63:0] nbits;
		logic [255:0] dig;
		nbits = 64'(msg.size()) * 8;
		msg.push_back(8'h80);
		while (msg.size() % 64 != 56)
			msg.push_back(8'h00);
		for (int i = 0; i < 8; i++)
			msg.push_back(nbits[63 - 8 * i -: 8]);
		for (int i = 0; i < 8; i++)
			h[i] = hdrbg_pkg::SHA_IV[i];
		for (int blk = 0; blk < msg.size() / 64; blk++) begin
			for (int i = 0; i < 16; i++)
				w[i] = {msg[blk * 64 + 4 * i], msg[blk * 64 + 4 * i + 1],
					msg[blk * 64 + 4 * i + 2], msg[blk * 64 + 4 * i + 3]};
			for (int i = 16; i < 64; i++) begin
				s0 = rotr32(w[i - 15], 7) ^ rotr32(w[i - 15], 18) ^ (w[i - 15] >> 3);
				s1 = rotr32(w[i - 2], 17) ^ rotr32(w[i - 2], 19) ^ (w[i - 2] >> 10);
				w[i] = w[i - 16] + s0 + w[i - 7] + s1;
			end
			a = h[0]; b = h[1]; c = h[2]; d = h[3];
			e = h[4]; f = h[5]; g = h[6]; hh = h[7];
			for (int i = 0; i < 64; i++) begin
				t1 = hh + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) +
					((e & f) ^ (~e & g)) + hdrbg_pkg::SHA_K[i] + w[i];
				t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) +
					((a & b) ^ (a & c) ^ (b & c));
				hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
			end
			h[0] += a; h[1] += b; h[2] += c; h[3] += d;
			h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
		end
		for (int i = 0; i < 8; i++)
			dig[255 - 32 * i -: 32] = h[i];
		return dig;
	endfunction

	// 440-bit value as 55 bytes, most significant first.
	function automatic octet_q_t seed_bytes_of(logic [439:0] x);
		octet_q_t q;
		for (int j = 0; j < hdrbg_pkg::SEED_BYTES; j++)
			q.push_back(x[(hdrbg_pkg::SEED_BYTES - 1 - j) * 8 +: 8]);
		return q;
	endfunction

	function automatic logic [439:0] derive_seed(octet_q_t prefix, octet_q_t body);
		octet_q_t msg;
		logic [511:0] both;
		for (int k = 0; k < 2; k++) begin
			msg = {octet_t'(k + 1), 8'h00, 8'h00, 8'h01, 8'hB8};
			msg = {msg, prefix, body};
			both[511 - 256 * k -: 256] = sha256_of(msg);
		end
		return both[511:72];
	endfunction

	// Applies one accepted command to the tracked state and queues its output words.
	task automatic apply_command(logic [1:0] cmd, logic [7:0] data, logic [12:0] bits);
		octet_q_t msg;
		octet_t out_bytes[$];
		logic [439:0] counter_v;
		logic [255:0] dig;
		int nbytes, take, cnt;
		out_word_t ow;
		case (cmd)
			hdrbg_pkg::CMD_SEED: begin
				if (seed_q.size() < hdrbg_pkg::MAX_SEED_BYTES) begin
					seed_q.push_back(data);
					useful_cmds++;
				end
			end
			hdrbg_pkg::CMD_ADDIN: begin
				if (addin_q.size() < hdrbg_pkg::MAX_ADDIN_BYTES) begin
					addin_q.push_back(data);
					useful_cmds++;
				end
			end
			hdrbg_pkg::CMD_INST: begin
				useful_cmds++;
				inst_count++;
				msg.delete();
				drbg_v = derive_seed(msg, seed_q);
				msg.push_back(8'h00);
				drbg_c = derive_seed(msg, seed_bytes_of(drbg_v));
				drbg_ctr = 64'd1;
				seed_q.delete();
			end
			hdrbg_pkg::CMD_GEN: begin
				useful_cmds++;
				gen_count++;
				nbytes = (bits > hdrbg_pkg::REQ_MAX) ? hdrbg_pkg::REQ_MAX / 8
					: (int'(bits) + 7) / 8;
				if (addin_q.size() > 0) begin
					msg = {8'h02, seed_bytes_of(drbg_v), addin_q};
					drbg_v = drbg_v + 440'(sha256_of(msg));
					addin_q.delete();
				end
				counter_v = drbg_v;
				for (int off = 0; off < nbytes; off += 32) begin
					take = (nbytes - off < 32) ? nbytes - off : 32;
					dig = sha256_of(seed_bytes_of(counter_v));
					for (int i = 0; i < take; i++)
						out_bytes.push_back(dig[255 - 8 * i -: 8]);
					counter_v = counter_v + 440'd1;
				end
				msg = {8'h03, seed_bytes_of(drbg_v)};
				drbg_v = drbg_v + 440'(sha256_of(msg)) + drbg_c + 440'(drbg_ctr);
				drbg_ctr = drbg_ctr + 64'd1;
				for (int base = 0; base < nbytes; base += 8) begin
					cnt = (nbytes - base < 8) ? nbytes - base : 8;
					ow.word = '0;
					for (int j = 0; j < cnt; j++)
						ow.word[63 - 8 * j -: 8] = out_bytes[base + j];
					ow.nbytes = 4'(cnt);
					ow.last = (base + 8 >= nbytes);
					expected_words.push_back(ow);
				end
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// Input side: every accepted command is folded into the tracked state.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			apply_command(s_tuser, s_tdata[7:0], s_tdata[20:8]);
	end

	// Output side: each accepted word is compared with the oldest expectation.
	always @(posedge clk) begin
		out_word_t ow;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", m_tdata[63:0], 64'd0);
			end else begin
				ow = expected_words.pop_front();
				words_checked++;
				if (m_tdata[63:0] !== ow.word)
					report_mismatch("random_word", m_tdata[63:0], ow.word);
				if (m_tdata[67:64] !== ow.nbytes)
					report_mismatch("valid_bytes", 64'(m_tdata[67:64]), 64'(ow.nbytes));
				if (m_tlast !== ow.last)
					report_mismatch("last", 64'(m_tlast), 64'(ow.last));
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Drives one command and returns at the edge where it is taken.
	task automatic send_command(logic [1:0] cmd, logic [7:0] data, logic [12:0] bits);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, bits, data};
		do begin
			@(negedge clk);
		end while (!s_tready);
		@(posedge clk);
	endtask

	function automatic logic [12:0] random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 13'($urandom_range(0, 600));
		else if (r < 95)
			return 13'($urandom_range(0, hdrbg_pkg::REQ_MAX));
		return 13'($urandom_range(hdrbg_pkg::REQ_MAX + 1, 8191));
	endfunction

	stim_row_t directed[] = '{
		'{hdrbg_pkg::CMD_GEN,   8'h00, 13'd1},     // before instantiate, zero state, partial byte
		'{hdrbg_pkg::CMD_GEN,   8'h00, 13'd0},     // empty request still updates V
		'{hdrbg_pkg::CMD_SEED,  8'hFF, 13'd0},
		'{hdrbg_pkg::CMD_SEED,  8'h00, 13'd0},
		'{hdrbg_pkg::CMD_SEED,  8'hA5, 13'd8191},
		'{hdrbg_pkg::CMD_INST,  8'h00, 13'd0},
		'{hdrbg_pkg::CMD_GEN,   8'h00, 13'd64},
		'{hdrbg_pkg::CMD_ADDIN, 8'h00, 13'd0},
		'{hdrbg_pkg::CMD_ADDIN, 8'hFF, 13'd0},
		'{hdrbg_pkg::CMD_GEN,   8'h00, 13'd4096},  // largest request
		'{hdrbg_pkg::CMD_GEN,   8'h00, 13'd8191},  // saturates to the largest request
		'{hdrbg_pkg::CMD_GEN,   8'h00, 13'd7},
		'{hdrbg_pkg::CMD_GEN,   8'h00, 13'd65},
		'{hdrbg_pkg::CMD_INST,  8'h00, 13'd0},     // instantiate with no seed bytes
		'{hdrbg_pkg::CMD_GEN,   8'h00, 13'd256},
		'{hdrbg_pkg::CMD_SEED,  8'h5A, 13'd0},
		'{hdrbg_pkg::CMD_SEED,  8'hC3, 13'd0},
		'{hdrbg_pkg::CMD_INST,  8'hFF, 13'd4095},
		'{hdrbg_pkg::CMD_ADDIN, 8'h5A, 13'd0},
		'{hdrbg_pkg::CMD_GEN,   8'h00, 13'd0},     // additional input consumed by an empty request
		'{hdrbg_pkg::CMD_GEN,   8'h00, 13'd257}
	};

	initial begin
		int n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = hdrbg_pkg::CMD_SEED;
		m_tready = 1'b0;
		drbg_v = '0;
		drbg_c = '0;
		drbg_ctr = '0;
		error_count = 0;
		cycle_count = 0;
		useful_cmds = 0;
		words_checked = 0;
		gen_count = 0;
		inst_count = 0;
		send_gap_pct = 10;
		rx_stall_pct = 80;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_command(directed[i].cmd, directed[i].data, directed[i].bits);

		// Random part: mostly well-formed seed, instantiate, addin and generate runs.
		while (useful_cmds < TOTAL_CMDS) begin
			if (useful_cmds >= 2 * TOTAL_CMDS / 3) begin
				send_gap_pct = 0;
				rx_stall_pct = 0;
			end else if (useful_cmds >= TOTAL_CMDS / 3) begin
				send_gap_pct = 80;
				rx_stall_pct = 10;
			end
			if ($urandom_range(0, 99) < 15) begin
				// Occasionally overfill the seed buffer.
				n = ($urandom_range(0, 9) == 0) ? hdrbg_pkg::MAX_SEED_BYTES + 3
					: $urandom_range(0, 60);
				repeat (n) send_command(hdrbg_pkg::CMD_SEED, 8'($urandom), 13'($urandom));
				send_command(hdrbg_pkg::CMD_INST, 8'($urandom), 13'($urandom));
			end
			n = $urandom_range(1, 4);
			repeat (n) begin
				if ($urandom_range(0, 99) < 40) begin
					repeat (($urandom_range(0, 19) == 0) ? hdrbg_pkg::MAX_ADDIN_BYTES + 2
						: $urandom_range(1, 10))
						send_command(hdrbg_pkg::CMD_ADDIN, 8'($urandom), 13'($urandom));
				end
				send_command(hdrbg_pkg::CMD_GEN, 8'($urandom), random_request());
			end
			if ($urandom_range(0, 99) < 10)
				send_command(2'($urandom), 8'($urandom), random_request());
		end
		s_tvalid <= 1'b0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d output words from %0d generates and %0d instantiates,",
			words_checked, gen_count, inst_count);
		$display("under sender gaps, receiver stalls and back-to-back traffic.");
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d words outstanding", error_count,
				expected_words.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[sim.f]
design/hdrbg_pkg.sv
design/hdrbg_sha_core.sv
design/hdrbg_datapath.sv
design/hdrbg_ctrl.sv
design/hash_drbg_sha256_generator_core.sv
tb/hash_drbg_sha256_generator_core_tb.sv
